FILE: design/tsb_pkg.sv
package tsb_pkg;

  // Field widths of the command and result channels
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned PX_W     = 9;
  localparam int unsigned LINE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Register widths
  localparam int unsigned BG_W  = 16;
  localparam int unsigned SCR_W = 15;
  localparam int unsigned MW_W  = 13;
  localparam logic [MW_W-1:0] MAP_WIDTH_RESET = MW_W'(20);

  // Tile geometry
  localparam int unsigned TILE_SIDE  = 16;
  localparam int unsigned FINE_W     = $clog2(TILE_SIDE);
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned NUM_CODES  = 1 << CODE_W;
  localparam int unsigned TILE_DEPTH = 4096;
  localparam int unsigned TILE_AW    = $clog2(TILE_DEPTH);
  localparam int unsigned TRANSP_BIT = 15;

  // Map pixel coordinates: scroll plus screen position
  localparam int unsigned COORD_W = SCR_W + 1;
  localparam int unsigned TCOORD_W = COORD_W - FINE_W;
  localparam int unsigned ROW_W    = TCOORD_W + MW_W;

  // Map store; depth must be a power of two so the index wrap is a truncation
  localparam int unsigned MAP_DEPTH = 4096;
  localparam int unsigned MAP_AW    = $clog2(MAP_DEPTH);

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP_WR  = 2'd0,
    CMD_XLT_WR  = 2'd1,
    CMD_TILE_WR = 2'd2,
    CMD_RENDER  = 2'd3
  } tsb_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKDROP  = 2'd0,
    CFG_SCROLL_X  = 2'd1,
    CFG_SCROLL_Y  = 2'd2,
    CFG_MAP_WIDTH = 2'd3
  } tsb_cfg_idx_e;

  typedef struct packed {
    logic [BG_W-1:0]  backdrop;
    logic [SCR_W-1:0] scroll_x;
    logic [SCR_W-1:0] scroll_y;
    logic [MW_W-1:0]  map_width;
  } tsb_cfg_t;

  typedef struct packed {
    tsb_cmd_e           cmd;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
  } tsb_item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } tsb_deq_t;

endpackage

FILE: design/tsb_if.sv
interface tsb_in_if;
  logic                        valid;
  logic                        ready;
  tsb_pkg::tsb_cmd_e           cmd;
  logic [tsb_pkg::ADDR_W-1:0]  addr;
  logic [tsb_pkg::DATA_W-1:0]  data;
  logic [tsb_pkg::PX_W-1:0]    pixel_x;
  logic [tsb_pkg::LINE_W-1:0]  line;

  modport source (output valid, cmd, addr, data, pixel_x, line, input ready);
  modport sink   (input valid, cmd, addr, data, pixel_x, line, output ready);
endinterface

interface tsb_out_if;
  logic                        valid;
  logic                        ready;
  logic [tsb_pkg::DATA_W-1:0]  color;
  logic                        background_used;

  modport source (output valid, color, background_used, input ready);
  modport sink   (input valid, color, background_used, output ready);
endinterface

FILE: design/tile_scanline_background_unit.sv
// Channel  | Dir | Payload                                   | Transfer
// ---------+-----+-------------------------------------------+-------------------
// in_i     | in  | cmd, addr, data, pixel_x, line            | valid && ready
// out_o    | out | color, background_used                    | valid && ready
// cfg      | in  | cfg_idx_i, cfg_data_i                     | cfg_we_i
//
// One item per cycle sustained while out_o is not stalled; a render leaves out_o after
// passing the queue, the multiply stage, the map RAM read and the tile RAM read.
// Writes take the same path and give no result.
// After reset a clearing pass zeroes the map RAM, one entry a cycle, all MAP_DEPTH (4096)
// entries; in_i.ready stays low until it ends, configuration writes are taken as ever.
// A stalled out_o freezes the back pipeline; the two-entry queue fills up, then
// in_i.ready drops until the back end pops again.
module tile_scanline_background_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tsb_in_if.sink                        in_i,
  tsb_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [tsb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsb_pkg::BG_W-1:0]      cfg_data_i
);
  import tsb_pkg::*;

  tsb_cfg_t  cfg_q, cfg_d;
  tsb_deq_t  deq;
  tsb_item_t item;
  logic      item_valid;

  // Register file: decode the index and update one field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tsb_cfg_idx_e'(cfg_idx_i))
        CFG_BACKDROP:  cfg_d.backdrop  = cfg_data_i;
        CFG_SCROLL_X:  cfg_d.scroll_x  = cfg_data_i[SCR_W-1:0];
        CFG_SCROLL_Y:  cfg_d.scroll_y  = cfg_data_i[SCR_W-1:0];
        CFG_MAP_WIDTH: cfg_d.map_width = cfg_data_i[MW_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backdrop  <= '0;
      cfg_q.scroll_x  <= '0;
      cfg_q.scroll_y  <= '0;
      cfg_q.map_width <= MAP_WIDTH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept, add scroll, queue
  tsb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .deq_i        (deq),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // Back: map lookup, translate, tile fetch, transparency select
  tsb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .deq_o        (deq),
    .out_o        (out_o)
  );

`ifndef NO_ASSERTIONS
  // No transfer on the input side while the map is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq.clearing |-> !in_i.ready)
    else $error("input ready during map clear");

  // No result can exist while the map clear runs
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !deq.clearing)
    else $error("result offered during map clear");

  // The back end only pops a queue that holds an item
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq.pop |-> item_valid)
    else $error("pop from empty queue");

  // Clear ends once and never restarts without reset
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !deq.clearing |=> !deq.clearing)
    else $error("map clear restarted");
`endif

endmodule

FILE: design/tsb_ram.sv
module tsb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/tsb_front.sv
module tsb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  tsb_in_if.sink             in_i,
  input  tsb_pkg::tsb_cfg_t  cfg_i,
  input  tsb_pkg::tsb_deq_t  deq_i,
  output logic               item_valid_o,
  output tsb_pkg::tsb_item_t item_o
);
  import tsb_pkg::*;

  tsb_item_t         q_mem_q [QDEPTH];
  logic [QAW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  tsb_item_t         push_item;

  // Hold off while the map clear runs or the queue is full
  assign in_i.ready = (cnt_q != QCNT_W'(QDEPTH)) && !deq_i.clearing;
  assign push       = in_i.valid && in_i.ready;

  // Add the scroll offsets on entry to get map pixel coordinates
  always_comb begin
    push_item.cmd  = in_i.cmd;
    push_item.addr = in_i.addr;
    push_item.data = in_i.data;
    push_item.mx   = COORD_W'(cfg_i.scroll_x) + COORD_W'(in_i.pixel_x);
    push_item.my   = COORD_W'(cfg_i.scroll_y) + COORD_W'(in_i.line);
  end

  always_comb begin
    wr_ptr_d = push      ? QAW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = deq_i.pop ? QAW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    unique case ({push, deq_i.pop})
      2'b10:   cnt_d = QCNT_W'(cnt_q + 1'b1);
      2'b01:   cnt_d = QCNT_W'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= push_item;
    end
  end

  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem_q[rd_ptr_q];

endmodule

FILE: design/tsb_back.sv
module tsb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsb_pkg::tsb_cfg_t  cfg_i,
  input  logic               item_valid_i,
  input  tsb_pkg::tsb_item_t item_i,
  output tsb_pkg::tsb_deq_t  deq_o,
  tsb_out_if.source          out_o
);
  import tsb_pkg::*;

  // Map clear after reset
  logic              clearing_q, clearing_d;
  logic [MAP_AW-1:0] clr_cnt_q, clr_cnt_d;

  // Pipeline control
  logic adv;
  logic s1_valid_q, s2_valid_q, s3_valid_q;

  // Stage 1: tile row product and fine offsets
  tsb_cmd_e            s1_cmd_q;
  logic [ADDR_W-1:0]   s1_addr_q;
  logic [DATA_W-1:0]   s1_data_q;
  logic [ROW_W-1:0]    s1_row_q;
  logic [TCOORD_W-1:0] s1_col_q;
  logic [2*FINE_W-1:0] s1_fine_q;

  // Stage 2: map entry read back
  tsb_cmd_e            s2_cmd_q;
  logic [ADDR_W-1:0]   s2_addr_q;
  logic [DATA_W-1:0]   s2_data_q;
  logic [2*FINE_W-1:0] s2_fine_q;

  logic [CODE_W-1:0] xlt_q [NUM_CODES];

  logic [MAP_AW-1:0]  map_idx;
  logic               map_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [CODE_W-1:0]  map_wdata;
  logic [CODE_W-1:0]  map_rdata;
  logic [CODE_W-1:0]  code;
  logic               xlt_we;
  logic               tile_we;
  logic [TILE_AW-1:0] tile_raddr;
  logic [DATA_W-1:0]  pix;

  assign adv = !s3_valid_q || out_o.ready;

  assign deq_o.pop      = adv && item_valid_i && !clearing_q;
  assign deq_o.clearing = clearing_q;

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = MAP_AW'(clr_cnt_q + 1'b1);
      if (clr_cnt_q == MAP_AW'(MAP_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
      if (adv) begin
        s1_valid_q <= deq_o.pop;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q && (s2_cmd_q == CMD_RENDER);
      end
    end
  end

  // Stage 1 and stage 2 payload; stage 1 registers after the multiply
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q  <= item_i.cmd;
      s1_addr_q <= item_i.addr;
      s1_data_q <= item_i.data;
      s1_row_q  <= ROW_W'(item_i.my[COORD_W-1:FINE_W]) * ROW_W'(cfg_i.map_width);
      s1_col_q  <= item_i.mx[COORD_W-1:FINE_W];
      s1_fine_q <= {item_i.my[FINE_W-1:0], item_i.mx[FINE_W-1:0]};
      s2_cmd_q  <= s1_cmd_q;
      s2_addr_q <= s1_addr_q;
      s2_data_q <= s1_data_q;
      s2_fine_q <= s1_fine_q;
    end
  end

  // Map index wraps by truncation to the map address width
  assign map_idx = MAP_AW'(s1_row_q + ROW_W'(s1_col_q));

  always_comb begin
    if (clearing_q) begin
      map_we    = 1'b1;
      map_waddr = clr_cnt_q;
      map_wdata = '0;
    end else begin
      map_we    = adv && s1_valid_q && (s1_cmd_q == CMD_MAP_WR);
      map_waddr = MAP_AW'(s1_addr_q);
      map_wdata = s1_data_q[CODE_W-1:0];
    end
  end

  tsb_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (adv),
    .raddr_i (map_idx),
    .rdata_o (map_rdata)
  );

  // Translator: small register file, identity after reset
  assign xlt_we = adv && s2_valid_q && (s2_cmd_q == CMD_XLT_WR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        xlt_q[i] <= CODE_W'(i);
      end
    end else if (xlt_we) begin
      xlt_q[s2_addr_q[CODE_W-1:0]] <= s2_data_q[CODE_W-1:0];
    end
  end

  assign code       = xlt_q[map_rdata];
  assign tile_raddr = {code, s2_fine_q};
  assign tile_we    = adv && s2_valid_q && (s2_cmd_q == CMD_TILE_WR);

  tsb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TILE_DEPTH)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .waddr_i (TILE_AW'(s2_addr_q)),
    .wdata_i (s2_data_q),
    .re_i    (adv),
    .raddr_i (tile_raddr),
    .rdata_o (pix)
  );

  // Transparent pixels give the background colour
  assign out_o.valid           = s3_valid_q;
  assign out_o.background_used = pix[TRANSP_BIT];
  assign out_o.color           = pix[TRANSP_BIT] ? cfg_i.backdrop : pix;

endmodule

FILE: verif/tile_scanline_background_unit_tb.sv
module tile_scanline_background_unit_tb;
  import tsb_pkg::*;

  // One command as offered on the input channel
  typedef struct packed {
    tsb_cmd_e          cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [PX_W-1:0]   px;
    logic [LINE_W-1:0] ln;
  } bg_item_t;

  // One rendered pixel as it leaves the output channel
  typedef struct packed {
    logic [DATA_W-1:0] color;
    logic              bg_used;
  } pixel_t;

  // Directed row: either a register write (value in data) or a command,
  // optionally with the pixel typed in by hand
  typedef struct packed {
    logic              is_cfg;
    tsb_cfg_idx_e      ridx;
    tsb_cmd_e          cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [PX_W-1:0]   px;
    logic [LINE_W-1:0] ln;
    logic              typed;
    logic [DATA_W-1:0] want_color;
    logic              want_bg;
  } dir_row_t;

  localparam int unsigned DIR_ROWS    = 25;
  localparam int unsigned SEG_ITEMS   = 152;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PIPE_SLACK  = 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BG_W-1:0]      cfg_data_i;

  tsb_in_if  in_bus ();
  tsb_out_if out_bus ();

  tile_scanline_background_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the block: registers and the three memories
  logic [BG_W-1:0]   bg_reg;
  logic [SCR_W-1:0]  scroll_x_reg;
  logic [SCR_W-1:0]  scroll_y_reg;
  logic [MW_W-1:0]   width_reg;
  logic [CODE_W-1:0] map_mem [MAP_DEPTH];
  logic [CODE_W-1:0] xlt_mem [NUM_CODES];
  logic [DATA_W-1:0] tile_mem [TILE_DEPTH];
  bit                tile_seen [TILE_DEPTH];

  // Pixels still owed by the block, oldest first
  pixel_t pending_px [$];

  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  bit          hold_off_req = 1'b0;

  dir_row_t dir_rows [DIR_ROWS];

  // Tile RAM address that a render of (px, ln) reads under the current state
  function automatic logic [TILE_AW-1:0] tile_addr_at(input logic [PX_W-1:0] px,
                                                      input logic [LINE_W-1:0] ln);
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
    logic [31:0]        map_idx;
    logic [CODE_W-1:0]  code;
    mx = COORD_W'(scroll_x_reg) + COORD_W'(px);
    my = COORD_W'(scroll_y_reg) + COORD_W'(ln);
    // Row times width plus column, wrapped to the map depth
    map_idx = 32'(my >> FINE_W) * 32'(width_reg) + 32'(mx >> FINE_W);
    code = xlt_mem[map_mem[MAP_AW'(map_idx % MAP_DEPTH)]];
    return {code, my[FINE_W-1:0], mx[FINE_W-1:0]};
  endfunction

  // Apply one transferred command to the shadow state; renders yield a pixel
  function automatic void render_step(input bg_item_t itm, output bit yields,
                                      output pixel_t res);
    logic [DATA_W-1:0] pix;
    yields = 1'b0;
    res = '0;
    case (itm.cmd)
      CMD_MAP_WR: begin
        map_mem[itm.addr[MAP_AW-1:0]] = itm.data[CODE_W-1:0];
      end
      CMD_XLT_WR: begin
        xlt_mem[itm.addr[CODE_W-1:0]] = itm.data[CODE_W-1:0];
      end
      CMD_TILE_WR: begin
        tile_mem[itm.addr] = itm.data;
        tile_seen[itm.addr] = 1'b1;
      end
      default: begin
        pix = tile_mem[tile_addr_at(itm.px, itm.ln)];
        yields = 1'b1;
        res.bg_used = pix[TRANSP_BIT];
        res.color = pix[TRANSP_BIT] ? bg_reg : pix;
      end
    endcase
  endfunction

  // Offer one command until the block takes it, then book its pixel
  task automatic transfer(input bg_item_t itm, input bit typed, input pixel_t want);
    bit     yields;
    pixel_t got;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.cmd     <= itm.cmd;
    in_bus.addr    <= itm.addr;
    in_bus.data    <= itm.data;
    in_bus.pixel_x <= itm.px;
    in_bus.line    <= itm.ln;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sent++;
    render_step(itm, yields, got);
    if (yields) pending_px.push_back(typed ? want : got);
  endtask

  // A render must never read an unwritten tile pixel: write that pixel first
  task automatic offer(input bg_item_t itm, input bit typed, input pixel_t want);
    bg_item_t           fill;
    logic [TILE_AW-1:0] target;
    if (itm.cmd == CMD_RENDER) begin
      target = tile_addr_at(itm.px, itm.ln);
      if (!tile_seen[target]) begin
        fill      = itm;
        fill.cmd  = CMD_TILE_WR;
        fill.addr = target;
        fill.data = DATA_W'($urandom_range(0, 65535));
        transfer(fill, 1'b0, '0);
      end
    end
    transfer(itm, typed, want);
  endtask

  // Drop valid, wait for every owed pixel, then let the pipeline run dry
  task automatic settle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  task automatic set_reg(input tsb_cfg_idx_e idx, input logic [BG_W-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_BACKDROP: bg_reg       = val;
      CFG_SCROLL_X: scroll_x_reg = val[SCR_W-1:0];
      CFG_SCROLL_Y: scroll_y_reg = val[SCR_W-1:0];
      default:      width_reg    = val[MW_W-1:0];
    endcase
  endtask

  // Receiver: random back-pressure, plus a long hold-off when asked for
  initial begin
    int unsigned held;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        // Hold ready low long enough for the queue to fill and stall in_i
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      out_bus.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Compare each pixel transfer with the oldest owed pixel
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_px.size() == 0) begin
        $error("unexpected pixel: color %h background_used %b",
               out_bus.color, out_bus.background_used);
        errors++;
      end else begin
        want = pending_px.pop_front();
        if (out_bus.color !== want.color) begin
          $error("color mismatch: expected %h, actual %h", want.color, out_bus.color);
          errors++;
        end
        if (out_bus.background_used !== want.bg_used) begin
          $error("background_used mismatch: expected %b, actual %b",
                 want.bg_used, out_bus.background_used);
          errors++;
        end
      end
    end
  end

  // Watchdog: clearing pass, stalls and drains fit many times over
  initial begin
    #(20 * 600_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bg_item_t    itm;
    int unsigned mode;
    int unsigned setting;
    int unsigned k;
    int unsigned pick;
    int unsigned spin;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_BACKDROP;
    cfg_data_i     = '0;
    in_bus.valid   = 1'b0;
    in_bus.cmd     = CMD_MAP_WR;
    in_bus.addr    = '0;
    in_bus.data    = '0;
    in_bus.pixel_x = '0;
    in_bus.line    = '0;

    // Shadow state after reset: map cleared, translator identity
    bg_reg       = '0;
    scroll_x_reg = '0;
    scroll_y_reg = '0;
    width_reg    = MAP_WIDTH_RESET;
    foreach (map_mem[i]) map_mem[i] = '0;
    foreach (xlt_mem[i]) xlt_mem[i] = CODE_W'(i);
    foreach (tile_mem[i]) begin
      tile_mem[i]  = '0;
      tile_seen[i] = 1'b0;
    end

    // Fields: cfg, reg, cmd, addr, data/value, px, line, typed, color, bg
    dir_rows = '{
      '{1'b0, CFG_BACKDROP,  CMD_TILE_WR, 12'h000, 16'h1234, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'h000, 16'h0000, 9'd0,   8'd0,   1'b1, 16'h1234, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_TILE_WR, 12'h00F, 16'h8000, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'h000, 16'h0000, 9'd15,  8'd0,   1'b1, 16'h0000, 1'b1},
      '{1'b1, CFG_BACKDROP,  CMD_MAP_WR,  12'h000, 16'hFFFF, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'hFFF, 16'hFFFF, 9'd15,  8'd0,   1'b1, 16'hFFFF, 1'b1},
      '{1'b0, CFG_BACKDROP,  CMD_TILE_WR, 12'h0FF, 16'h7FFF, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'h000, 16'h0000, 9'd15,  8'd15,  1'b1, 16'h7FFF, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_TILE_WR, 12'hFFF, 16'hFFFF, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_MAP_WR,  12'hFFF, 16'hFFFF, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      // only the low address bits select a translator entry
      '{1'b0, CFG_BACKDROP,  CMD_XLT_WR,  12'hFF3, 16'hFFF7, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_MAP_WR,  12'h001, 16'h0003, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'h000, 16'h0000, 9'd31,  8'd0,   1'b0, 16'h0, 1'b0},
      // wide map row, scroll at its limits: the index wraps
      '{1'b1, CFG_MAP_WIDTH, CMD_MAP_WR,  12'h000, 16'h1000, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b1, CFG_SCROLL_X,  CMD_MAP_WR,  12'h000, 16'hFFFF, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b1, CFG_SCROLL_Y,  CMD_MAP_WR,  12'h000, 16'h7FFF, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'h000, 16'h0000, 9'd319, 8'd239, 1'b0, 16'h0, 1'b0},
      // column and line beyond the screen go into the sum unclipped
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'hFFF, 16'hFFFF, 9'd511, 8'd255, 1'b0, 16'h0, 1'b0},
      // zero width reads row 0 only
      '{1'b1, CFG_MAP_WIDTH, CMD_MAP_WR,  12'h000, 16'h0000, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'h000, 16'h0000, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b1, CFG_MAP_WIDTH, CMD_MAP_WR,  12'h000, 16'h1FFF, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'h000, 16'h0000, 9'd511, 8'd255, 1'b0, 16'h0, 1'b0},
      '{1'b1, CFG_BACKDROP,  CMD_MAP_WR,  12'h000, 16'h0000, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_XLT_WR,  12'h003, 16'h0003, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0},
      '{1'b0, CFG_BACKDROP,  CMD_RENDER,  12'h000, 16'h0000, 9'd0,   8'd0,   1'b0, 16'h0, 1'b0}
    };

    // Hold reset, then release it away from the rising edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: walk the table; the clearing pass holds off the first transfer
    src_idle_pct = 28;
    dst_idle_pct = 69;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        set_reg(dir_rows[i].ridx, dir_rows[i].data);
      end else begin
        itm = '{dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].data,
                dir_rows[i].px, dir_rows[i].ln};
        offer(itm, dir_rows[i].typed, '{dir_rows[i].want_color, dir_rows[i].want_bg});
      end
    end

    // Random part: three idling modes, four register settings each
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct = 28;
          dst_idle_pct = 69;
        end
        1: begin
          src_idle_pct = 69;
          dst_idle_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      for (setting = 0; setting < 4; setting++) begin
        case (setting)
          0: begin
            // reset-like view, random background
            set_reg(CFG_BACKDROP, BG_W'($urandom_range(0, 65535)));
            set_reg(CFG_SCROLL_X, '0);
            set_reg(CFG_SCROLL_Y, '0);
            set_reg(CFG_MAP_WIDTH, BG_W'(MAP_WIDTH_RESET));
          end
          1: begin
            // every register at its top but the map width, set to 4096
            set_reg(CFG_BACKDROP, 16'hFFFF);
            set_reg(CFG_SCROLL_X, 16'hFFFF);
            set_reg(CFG_SCROLL_Y, 16'hFFFF);
            set_reg(CFG_MAP_WIDTH, 16'h1000);
          end
          2: begin
            // full 16-bit values; the block keeps only the register's width
            set_reg(CFG_BACKDROP, BG_W'($urandom_range(0, 65535)));
            set_reg(CFG_SCROLL_X, BG_W'($urandom_range(0, 65535)));
            set_reg(CFG_SCROLL_Y, BG_W'($urandom_range(0, 65535)));
            set_reg(CFG_MAP_WIDTH, BG_W'($urandom_range(0, 65535)));
          end
          default: begin
            // narrow maps, zero width among them
            set_reg(CFG_BACKDROP, '0);
            set_reg(CFG_SCROLL_X, BG_W'($urandom_range(0, 32767)));
            set_reg(CFG_SCROLL_Y, BG_W'($urandom_range(0, 32767)));
            set_reg(CFG_MAP_WIDTH, BG_W'($urandom_range(0, 2)));
          end
        endcase
        // With no idling, stall the receiver while the sender keeps offering
        if (mode == 2 && setting != 3) hold_off_req = 1'b1;
        // Count tile fills as well, so each segment moves about SEG_ITEMS transfers
        k = sent;
        while (sent - k < SEG_ITEMS) begin
          pick     = $urandom_range(99);
          itm.addr = ADDR_W'($urandom_range(0, 4095));
          itm.data = DATA_W'($urandom_range(0, 65535));
          itm.px   = ($urandom_range(99) < 80) ? PX_W'($urandom_range(0, 319))
                                               : PX_W'($urandom_range(0, 511));
          itm.ln   = ($urandom_range(99) < 80) ? LINE_W'($urandom_range(0, 239))
                                               : LINE_W'($urandom_range(0, 255));
          if (pick < 55) begin
            itm.cmd = CMD_RENDER;
          end else if (pick < 70) begin
            itm.cmd = CMD_MAP_WR;
            // bias map writes towards the rows that renders tend to hit
            if ($urandom_range(99) < 70) itm.addr = ADDR_W'($urandom_range(0, 511));
          end else if (pick < 80) begin
            itm.cmd = CMD_XLT_WR;
          end else begin
            itm.cmd = CMD_TILE_WR;
          end
          offer(itm, 1'b0, '0);
        end
      end
    end

    // Drain: wait for the last pixels, bounded, then let the pipeline empty
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    for (spin = 0; spin < 20000 && pending_px.size() != 0; spin++) @(posedge clk_i);
    if (pending_px.size() != 0) begin
      $error("%0d pixels never arrived", pending_px.size());
      errors++;
    end
    repeat (PIPE_SLACK) @(posedge clk_i);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: tile_scanline_background_unit.f
design/tsb_pkg.sv
design/tsb_if.sv
design/tsb_ram.sv
design/tsb_front.sv
design/tsb_back.sv
design/tile_scanline_background_unit.sv
verif/tile_scanline_background_unit_tb.sv
